@@ design/mspwm_pkg.sv @@
// ----------------------------------------------------------------------------
// mspwm_pkg
// Shared types and constants of the shadowed multichannel PWM generator.
// ----------------------------------------------------------------------------
package mspwm_pkg;

    localparam int NUM_CHANNELS_DEFAULT = 8;
    localparam int PIN_COUNT            = 8;

    localparam logic [7:0]  DUTY_ALWAYS_ON = 8'd255;
    localparam logic [15:0] PERIOD_RESET   = 16'd390;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [2:0] channel;
        logic [7:0] duty;
    } mspwm_item_t;

    typedef struct packed {
        logic [PIN_COUNT-1:0] pin_levels;
        logic                 housekeeping_pulse;
        logic [7:0]           phase;
    } mspwm_result_t;

endpackage

@@ design/mspwm_in_stage.sv @@
// ----------------------------------------------------------------------------
// mspwm_in_stage
// Input register; holds one item while the result side is stalled.
// ----------------------------------------------------------------------------
module mspwm_in_stage
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  mspwm_pkg::mspwm_item_t in_item,
    input  logic                   take,
    output logic                   item_valid,
    output mspwm_pkg::mspwm_item_t item
);

    logic                   valid_reg;
    mspwm_pkg::mspwm_item_t item_reg;

    assign in_stall   = valid_reg && !take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ design/mspwm_core.sv @@
// ----------------------------------------------------------------------------
// mspwm_core
// Duty shadow registers, phase and housekeeping counters, and per-channel
// compare logic that forms the result of one item.
// ----------------------------------------------------------------------------
module mspwm_core
#(
    parameter int NUM_CHANNELS = mspwm_pkg::NUM_CHANNELS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_enable,
    input  logic [15:0]              cfg_write_data,
    input  logic                     advance,
    input  mspwm_pkg::mspwm_item_t   item,
    output mspwm_pkg::mspwm_result_t result
);

    localparam int LIVE = (NUM_CHANNELS < mspwm_pkg::PIN_COUNT) ?
                          NUM_CHANNELS : mspwm_pkg::PIN_COUNT;

    logic [7:0]      pending_reg [LIVE];
    logic [7:0]      pending_next [LIVE];
    logic [7:0]      latched_reg [LIVE];
    logic [7:0]      latched_next [LIVE];
    logic [LIVE-1:0] bits_reg;
    logic [LIVE-1:0] bits_next;
    logic [7:0]      phase_count_reg;
    logic [7:0]      phase_count_next;
    logic [15:0]     hk_count_reg;
    logic [15:0]     hk_count_next;
    logic [15:0]     period_reg;
    logic [16:0]     hk_sum;
    logic            pulse;

    assign hk_sum = 17'(hk_count_reg) + 17'd1;

    always_comb
    begin
        pending_next     = pending_reg;
        latched_next     = latched_reg;
        bits_next        = bits_reg;
        phase_count_next = phase_count_reg;
        hk_count_next    = hk_count_reg;
        pulse            = 1'b0;
        if (item.kind == mspwm_pkg::KIND_WRITE)
        begin
            for (int i = 0; i < LIVE; i++)
            begin
                if (item.channel == 3'(i))
                begin
                    pending_next[i] = item.duty;
                end
            end
        end
        else
        begin
            for (int i = 0; i < LIVE; i++)
            begin
                if (phase_count_reg == 8'd0)
                begin
                    latched_next[i] = pending_reg[i];
                    if (pending_reg[i] != 8'd0)
                    begin
                        bits_next[i] = 1'b1;
                    end
                end
                if (latched_next[i] == phase_count_reg &&
                    latched_next[i] != mspwm_pkg::DUTY_ALWAYS_ON)
                begin
                    bits_next[i] = 1'b0;
                end
            end
            if (hk_sum >= 17'(period_reg))
            begin
                hk_count_next = 16'd0;
                pulse         = 1'b1;
            end
            else
            begin
                hk_count_next = hk_sum[15:0];
            end
            phase_count_next = phase_count_reg + 8'd1;
        end
    end

    always_comb
    begin
        result.pin_levels = '0;
        for (int i = 0; i < LIVE; i++)
        begin
            result.pin_levels[i] = bits_next[i];
        end
        result.housekeeping_pulse = pulse;
        result.phase              = phase_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIVE; i++)
            begin
                pending_reg[i] <= 8'd0;
                latched_reg[i] <= 8'd0;
            end
            bits_reg        <= '0;
            phase_count_reg <= 8'd0;
            hk_count_reg    <= 16'd0;
        end
        else if (advance)
        begin
            pending_reg     <= pending_next;
            latched_reg     <= latched_next;
            bits_reg        <= bits_next;
            phase_count_reg <= phase_count_next;
            hk_count_reg    <= hk_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= mspwm_pkg::PERIOD_RESET;
        end
        else if (cfg_write_enable)
        begin
            period_reg <= cfg_write_data;
        end
    end

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_count_reg) && $stable(hk_count_reg) && $stable(bits_reg))
        else $error("Counters or pins moved without an item.");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.kind == mspwm_pkg::KIND_TICK
        |=> phase_count_reg == 8'($past(phase_count_reg) + 8'd1))
        else $error("Phase did not advance by one on a tick.");

    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.kind == mspwm_pkg::KIND_WRITE
        |=> $stable(phase_count_reg) && $stable(hk_count_reg) && $stable(bits_reg))
        else $error("A duty write changed counters or pins.");

endmodule

@@ design/mspwm_out_stage.sv @@
// ----------------------------------------------------------------------------
// mspwm_out_stage
// Result register that holds a result until the receiver takes it.
// ----------------------------------------------------------------------------
module mspwm_out_stage
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  mspwm_pkg::mspwm_result_t result,
    output logic                     take,
    output logic                     advance,
    output logic                     out_valid,
    input  logic                     out_stall,
    output mspwm_pkg::mspwm_result_t out_result
);

    logic                     valid_reg;
    mspwm_pkg::mspwm_result_t result_reg;

    assign take       = !valid_reg || !out_stall;
    assign advance    = item_valid && take;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

endmodule

@@ design/multichannel_shadowed_pwm.sv @@
// ----------------------------------------------------------------------------
// multichannel_shadowed_pwm
// Multichannel 8-bit PWM generator with shadowed duties and a housekeeping
// pulse counter.
//
// Each input item is either a PWM tick (kind 0) or a pending-duty write
// (kind 1, with channel and duty). Every item yields exactly one result item
// carrying the pin levels, the housekeeping pulse and the phase after it.
// An item is accepted on a clock edge where in_valid is high and in_stall is
// low; a result is taken where out_valid is high and out_stall is low.
// The result of an accepted item is formed by the compare logic from the
// input register and is registered in the result register, which drives
// out_valid. Throughput is one item per cycle while out_stall is low, set by
// the input register feeding the compare logic and the result register.
// When the receiver stalls, the result register holds and one more item is
// taken into the input register; in_stall then rises until the result goes.
// The housekeeping period is written through cfg_write_enable and
// cfg_write_data. Reset clears all duties, counters and pins and sets the
// period to 390 ticks; all channels come up empty.
// ----------------------------------------------------------------------------
module multichannel_shadowed_pwm
#(
    parameter int NUM_CHANNELS = mspwm_pkg::NUM_CHANNELS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_enable,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [2:0]  channel,
    input  logic [7:0]  duty,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  pin_levels,
    output logic        housekeeping_pulse,
    output logic [7:0]  phase
);

    mspwm_pkg::mspwm_item_t   in_item;
    mspwm_pkg::mspwm_item_t   item;
    mspwm_pkg::mspwm_result_t result;
    mspwm_pkg::mspwm_result_t out_result;
    logic                     item_valid;
    logic                     take;
    logic                     advance;

    assign in_item.kind    = kind;
    assign in_item.channel = channel;
    assign in_item.duty    = duty;

    mspwm_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    mspwm_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .advance          (advance),
        .item             (item),
        .result           (result)
    );

    mspwm_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .take       (take),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign pin_levels         = out_result.pin_levels;
    assign housekeeping_pulse = out_result.housekeeping_pulse;
    assign phase              = out_result.phase;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("Input stalled while the result side was free.");

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the shadowed multichannel PWM generator. A directed sequence
// and a long random sequence of ticks and duty writes run through both
// valid/stall channels, with random idle gaps and receiver stalls. Each result
// is checked field by field against an in-bench model of the duty shadowing,
// pin levels, phase counter and housekeeping pulse. The housekeeping period is
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CHANNELS    = mspwm_pkg::NUM_CHANNELS_DEFAULT;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic        KIND_TICK   = mspwm_pkg::KIND_TICK;
    localparam logic        KIND_WRITE  = mspwm_pkg::KIND_WRITE;

    typedef enum logic
    {
        ROW_ITEM,
        ROW_CFG
    } row_op_t;

    typedef struct
    {
        row_op_t                  op;
        mspwm_pkg::mspwm_item_t   item;
        int unsigned              reps;
        logic                     typed;
        mspwm_pkg::mspwm_result_t want;
        logic [15:0]              period;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_enable = 1'b0;
    logic [15:0] cfg_write_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = KIND_TICK;
    logic [2:0]  channel = '0;
    logic [7:0]  duty = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  pin_levels;
    logic        housekeeping_pulse;
    logic [7:0]  phase;

    logic                     typed_on = 1'b0;
    mspwm_pkg::mspwm_result_t typed_result = '0;
    logic                     no_idle = 1'b0;

    logic [7:0]  shadow_duty [CHANNELS] = '{default: '0};
    logic [7:0]  active_duty [CHANNELS] = '{default: '0};
    logic [7:0]  phase_ctr = '0;
    logic [7:0]  pin_state = '0;
    logic [15:0] hk_count = '0;
    logic [15:0] hk_period = mspwm_pkg::PERIOD_RESET;

    mspwm_pkg::mspwm_result_t awaited_results [$];
    int unsigned              fault_count = 0;
    int unsigned              cycle_count = 0;

    plan_row_t directed_plan [25] = '{
        '{ROW_ITEM, '{KIND_TICK,  3'd0, 8'd0},   1,   1'b1, '{8'h00, 1'b0, 8'd1},   16'd0},
        '{ROW_ITEM, '{KIND_WRITE, 3'd0, 8'd255}, 1,   1'b1, '{8'h00, 1'b0, 8'd1},   16'd0},
        '{ROW_ITEM, '{KIND_WRITE, 3'd7, 8'd1},   1,   1'b1, '{8'h00, 1'b0, 8'd1},   16'd0},
        '{ROW_ITEM, '{KIND_WRITE, 3'd3, 8'd0},   1,   1'b1, '{8'h00, 1'b0, 8'd1},   16'd0},
        '{ROW_ITEM, '{KIND_WRITE, 3'd1, 8'd2},   1,   1'b0, '0,                     16'd0},
        '{ROW_ITEM, '{KIND_WRITE, 3'd2, 8'd128}, 1,   1'b0, '0,                     16'd0},
        '{ROW_ITEM, '{KIND_WRITE, 3'd4, 8'd85},  1,   1'b0, '0,                     16'd0},
        '{ROW_ITEM, '{KIND_WRITE, 3'd5, 8'd170}, 1,   1'b0, '0,                     16'd0},
        '{ROW_ITEM, '{KIND_WRITE, 3'd6, 8'd254}, 1,   1'b0, '0,                     16'd0},
        '{ROW_ITEM, '{KIND_TICK,  3'd7, 8'd255}, 254, 1'b0, '0,                     16'd0},
        '{ROW_ITEM, '{KIND_TICK,  3'd0, 8'd0},   1,   1'b1, '{8'h00, 1'b0, 8'd0},   16'd0},
        '{ROW_ITEM, '{KIND_TICK,  3'd0, 8'd0},   1,   1'b1, '{8'hF7, 1'b0, 8'd1},   16'd0},
        '{ROW_ITEM, '{KIND_TICK,  3'd0, 8'd0},   1,   1'b1, '{8'h77, 1'b0, 8'd2},   16'd0},
        '{ROW_ITEM, '{KIND_WRITE, 3'd7, 8'd0},   1,   1'b1, '{8'h77, 1'b0, 8'd2},   16'd0},
        '{ROW_ITEM, '{KIND_TICK,  3'd0, 8'd0},   1,   1'b1, '{8'h75, 1'b0, 8'd3},   16'd0},
        '{ROW_ITEM, '{KIND_TICK,  3'd5, 8'd170}, 130, 1'b0, '0,                     16'd0},
        '{ROW_ITEM, '{KIND_TICK,  3'd0, 8'd0},   1,   1'b1, '{8'h61, 1'b1, 8'd134}, 16'd0},
        '{ROW_ITEM, '{KIND_TICK,  3'd2, 8'd85},  40,  1'b0, '0,                     16'd0},
        '{ROW_CFG,  '{KIND_TICK,  3'd0, 8'd0},   0,   1'b0, '0,                     16'd10},
        '{ROW_ITEM, '{KIND_TICK,  3'd0, 8'd0},   1,   1'b0, '0,                     16'd0},
        '{ROW_CFG,  '{KIND_TICK,  3'd0, 8'd0},   0,   1'b0, '0,                     16'd0},
        '{ROW_ITEM, '{KIND_TICK,  3'd0, 8'd0},   3,   1'b0, '0,                     16'd0},
        '{ROW_CFG,  '{KIND_TICK,  3'd0, 8'd0},   0,   1'b0, '0,                     16'hFFFF},
        '{ROW_ITEM, '{KIND_TICK,  3'd0, 8'd0},   20,  1'b0, '0,                     16'd0},
        '{ROW_ITEM, '{KIND_WRITE, 3'd3, 8'd255}, 1,   1'b0, '0,                     16'd0}
    };

    multichannel_shadowed_pwm i_dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_enable   (cfg_write_enable),
        .cfg_write_data     (cfg_write_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .kind               (kind),
        .channel            (channel),
        .duty               (duty),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .pin_levels         (pin_levels),
        .housekeeping_pulse (housekeeping_pulse),
        .phase              (phase)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic mspwm_pkg::mspwm_result_t next_pwm_result(
        input mspwm_pkg::mspwm_item_t it);
        mspwm_pkg::mspwm_result_t res;
        logic [16:0]              next_count;
        res.housekeeping_pulse = 1'b0;
        if (it.kind == KIND_WRITE)
        begin
            if (int'(it.channel) < CHANNELS)
                shadow_duty[it.channel] = it.duty;
        end
        else
        begin
            if (phase_ctr == 8'd0)
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    active_duty[i] = shadow_duty[i];
                    if (active_duty[i] != 8'd0)
                        pin_state[i] = 1'b1;
                end
            end
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (active_duty[i] == phase_ctr &&
                    active_duty[i] != mspwm_pkg::DUTY_ALWAYS_ON)
                    pin_state[i] = 1'b0;
            end
            next_count = {1'b0, hk_count} + 17'd1;
            if (next_count >= {1'b0, hk_period})
            begin
                hk_count = '0;
                res.housekeeping_pulse = 1'b1;
            end
            else
            begin
                hk_count = next_count[15:0];
            end
            phase_ctr = phase_ctr + 8'd1;
        end
        res.pin_levels = pin_state;
        res.phase      = phase_ctr;
        return res;
    endfunction

    task automatic log_fault(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        fault_count++;
    endtask

    always @(posedge clk)
    begin : scoreboard
        mspwm_pkg::mspwm_result_t want;
        mspwm_pkg::mspwm_item_t   taken;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    log_fault($sformatf("unexpected result pins=%h pulse=%b phase=%0d",
                                        pin_levels, housekeeping_pulse, phase));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (pin_levels !== want.pin_levels)
                        log_fault($sformatf("pin_levels got %h want %h",
                                            pin_levels, want.pin_levels));
                    if (housekeeping_pulse !== want.housekeeping_pulse)
                        log_fault($sformatf("housekeeping_pulse got %b want %b",
                                            housekeeping_pulse, want.housekeeping_pulse));
                    if (phase !== want.phase)
                        log_fault($sformatf("phase got %0d want %0d", phase, want.phase));
                end
            end
            if (cfg_write_enable)
                hk_period = cfg_write_data;
            if (in_valid && !in_stall)
            begin
                taken = '{kind, channel, duty};
                want  = next_pwm_result(taken);
                if (typed_on)
                    want = typed_result;
                awaited_results.push_back(want);
            end
        end
    end

    function automatic int unsigned pick_idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic mspwm_pkg::mspwm_item_t random_pwm_item();
        mspwm_pkg::mspwm_item_t it;
        it.kind    = ($urandom_range(0, 99) < 80) ? KIND_TICK : KIND_WRITE;
        it.channel = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0: it.duty = 8'd0;
            1: it.duty = 8'd1;
            2: it.duty = 8'd254;
            3: it.duty = mspwm_pkg::DUTY_ALWAYS_ON;
            default: it.duty = 8'($urandom());
        endcase
        return it;
    endfunction

    task automatic send_item(input mspwm_pkg::mspwm_item_t it, input logic typed,
                             input mspwm_pkg::mspwm_result_t typed_val);
        int unsigned gap;
        gap = no_idle ? 0 : pick_idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= it.kind;
        channel      <= it.channel;
        duty         <= it.duty;
        typed_on     <= typed;
        typed_result <= typed_val;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_hk_period(input logic [15:0] value);
        wait_all_results();
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    initial
    begin : receiver
        int unsigned n;
        forever
        begin
            n = no_idle ? 0 : pick_idle_len();
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : stimulus
        logic [15:0] period;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[r])
        begin
            if (directed_plan[r].op == ROW_CFG)
                write_hk_period(directed_plan[r].period);
            else
                repeat (directed_plan[r].reps)
                    send_item(directed_plan[r].item, directed_plan[r].typed,
                              directed_plan[r].want);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: period = 16'd1;
                1: period = 16'($urandom_range(2, 40));
                2: period = 16'd0;
                3: period = 16'($urandom_range(1, 65535));
                4: period = 16'hFFFF;
                5: period = 16'($urandom_range(2, 12));
                6: period = mspwm_pkg::PERIOD_RESET;
                default: period = 16'($urandom_range(1, 300));
            endcase
            write_hk_period(period);
            no_idle = (ph == 3 || ph == 6);
            for (int n = 0; n < 70; n++)
            begin
                if (ph == 2 && n == 35)
                    wait_all_results();
                send_item(random_pwm_item(), 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        wait_all_results();
        repeat (8) @(posedge clk);
        if (fault_count == 0 && awaited_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
